FILE: rtl/core/assert_macros.svh
// Assertion macros used by the allocator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define VRA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define VRA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/vra_pkg.sv
// Types, constants and codes of the vertex range allocator.
package vra_pkg;

    localparam int FREE_ENTRIES   = 64;
    localparam int SCAN_LIMIT     = 10;
    localparam int FRAME_SLOTS    = 2;
    localparam int DEFERRED_DEPTH = 64;
    localparam int POOL_VERTS     = 1048576;

    localparam int START_W = 20;
    localparam int LEN_W   = 21;
    localparam int BYTES_W = 29;
    localparam int VS_W    = 9;
    localparam int PROD_W  = LEN_W + VS_W;

    localparam int FIDX_W  = $clog2(FREE_ENTRIES);
    localparam int FCNT_W  = $clog2(FREE_ENTRIES + 1);
    localparam int SCAN_W  = $clog2(SCAN_LIMIT + 1);
    localparam int SLOT_W  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int DIDX_W  = $clog2(DEFERRED_DEPTH);
    localparam int DCNT_W  = $clog2(DEFERRED_DEPTH + 1);
    localparam int DADDR_W = SLOT_W + DIDX_W;

    localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
    localparam logic [VS_W-1:0]    VS_RESET  = VS_W'(32);
    localparam logic [LEN_W-1:0]   POOL_CAP  =
        (POOL_VERTS > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(POOL_VERTS);

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_FRAME = 2'd2,
        MODE_INIT  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FREE_FULL = 2'd2,
        ST_DEF_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        COP_HOLD,
        COP_ROT,
        COP_SORT,
        COP_MDEL,
        COP_WRITE
    } t_chain_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_ADD,
        S_SORT,
        S_MERGE,
        S_ALIGN,
        S_REL_START,
        S_REL_RD,
        S_REL_WR,
        S_REL_SUB,
        S_INIT_SET,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } t_entry;

    typedef struct packed {
        logic take_r;
        logic take_l;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        t_chain_op         op;
        logic [FIDX_W-1:0] idx;
        logic [FCNT_W-1:0] lim;
        logic              odd;
        t_entry            wdata;
    } t_chain_ctl;

    typedef struct packed {
        t_mode              mode;
        logic [LEN_W-1:0]   count;
        logic [START_W-1:0] start_req;
    } t_in;

    typedef struct packed {
        logic [START_W-1:0] grant_start;
        logic [LEN_W-1:0]   grant_length;
        t_status            status;
        logic [BYTES_W-1:0] allocated_bytes;
    } t_out;

endpackage

FILE: rtl/core/vertex_range_allocator_core.sv
// Vertex range allocator: free list, deferred frees and byte count.
//
// Usage: one request on i_in (mode, count, start_req) gives exactly one
// result on o_out. Both channels use valid/stall; o_in_stall is high while
// a request is in progress. The config channel writes vertex_size
// (i_cfg_valid/o_cfg_ready, always ready) and is to be used only while the block
// idles, which the block does not enforce. Work per request is set by the free
// list chain (64 cells, one step a cycle) and the deferred memory (an entry read,
// pushed to the list and subtracted from the byte total in turn):
//   allocate: chain scan, apply, add (zero count: no scan; no fit: no add);
//   free range: a deferred write; frame end: when the list changed, sort rounds,
//     one merge step per live entry and a realign, then release of one slot;
//   init: release of every deferred range of every slot, then the list is set.
// Results sit in an output register; a stalled receiver holds it, and the
// block takes the next request meanwhile but finishes it only once the
// register frees up. Reset (synchronous, active low) clears counts, slot and
// byte total and sets vertex_size to 32; no clearing pass is run, the free list
// and deferred memory hold no data until written.
`include "assert_macros.svh"

module vertex_range_allocator_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  vra_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output vra_pkg::t_out               o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [vra_pkg::VS_W-1:0]    i_cfg_data
);
    import vra_pkg::*;

    t_state r_state, n_state;

    logic [VS_W-1:0]    r_vs;
    logic [FCNT_W-1:0]  r_used;
    logic [DCNT_W-1:0]  r_dused [FRAME_SLOTS];
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_rel_slot;
    logic               r_changed;
    logic [BYTES_W-1:0] r_bytes;
    logic               r_is_init;
    logic [LEN_W-1:0]   r_cnt;
    logic [FCNT_W-1:0]  r_step;
    logic               r_exact;
    logic [FIDX_W-1:0]  r_exact_idx;
    logic [SCAN_W-1:0]  r_n;
    logic               r_stop;
    t_entry             r_best;
    logic [FIDX_W-1:0]  r_best_idx;
    t_entry             r_last;
    logic [FCNT_W-1:0]  r_mlen;
    logic [FCNT_W-1:0]  r_fin;
    logic [DCNT_W-1:0]  r_ridx;
    logic               r_drop;
    logic [PROD_W-1:0]  r_prod;
    logic [START_W-1:0] r_gs;
    logic [LEN_W-1:0]   r_gl;
    t_status            r_st;
    logic               r_out_valid;
    t_out               r_out;

    t_chain_ctl         w_cctl;
    t_entry             w_head0;
    t_entry             w_head1;
    t_entry             w_rdata;
    logic               w_accept;
    logic               w_done_load;
    logic [SLOT_W-1:0]  w_dslot;
    logic [DCNT_W-1:0]  w_dcnt;
    logic               w_dfull;
    logic               w_mem_we;
    logic               w_mem_re;
    logic               w_merge;
    logic [LEN_W+1:0]   w_end;
    logic [LEN_W+1:0]   w_sum;
    logic               w_live;
    logic [LEN_W-1:0]   w_init_n;
    logic               w_rel_more;
    logic               w_rel_push;

    function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] b,
                                                  input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        begin
            s = (PROD_W+1)'(b) + (PROD_W+1)'(p);
            sat_add = (s > (PROD_W+1)'(BYTES_MAX)) ? BYTES_MAX : s[BYTES_W-1:0];
        end
    endfunction

    function automatic logic [BYTES_W-1:0] sat_sub(input logic [BYTES_W-1:0] b,
                                                  input logic [PROD_W-1:0] p);
        logic [PROD_W-1:0] d;
        begin
            d = PROD_W'(b) - p;
            sat_sub = (p > PROD_W'(b)) ? '0 : d[BYTES_W-1:0];
        end
    endfunction

    vra_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_cctl),
        .o_head0(w_head0),
        .o_head1(w_head1)
    );

    vra_dmem u_dmem (
        .i_clk  (i_clk),
        .i_we   (w_mem_we),
        .i_waddr({r_slot, w_dcnt[DIDX_W-1:0]}),
        .i_wdata({i_in.start_req, i_in.count}),
        .i_re   (w_mem_re),
        .i_raddr({r_rel_slot, r_ridx[DIDX_W-1:0]}),
        .o_rdata(w_rdata)
    );

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_done_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_dslot     = (r_state == S_IDLE) ? r_slot : r_rel_slot;
    assign w_dcnt      = r_dused[w_dslot];
    assign w_dfull     = (w_dcnt >= DCNT_W'(DEFERRED_DEPTH));
    assign w_mem_we    = w_accept && (i_in.mode == MODE_FREE) && !w_dfull;
    assign w_rel_more  = (r_ridx < w_dcnt);
    assign w_mem_re    = (r_state == S_REL_RD) && w_rel_more;
    assign w_live      = ({1'b0, r_step[FIDX_W-1:0]} < r_used);
    assign w_init_n    = (r_cnt > POOL_CAP) ? POOL_CAP : r_cnt;
    assign w_rel_push  = !r_is_init && (w_rdata.len != '0)
                       && (r_used < FCNT_W'(FREE_ENTRIES));

    assign w_end   = (LEN_W+2)'(w_head0.start) + (LEN_W+2)'(w_head0.len);
    assign w_sum   = (LEN_W+2)'(w_head0.len) + (LEN_W+2)'(w_head1.len);
    assign w_merge = (r_mlen >= FCNT_W'(2)) && (w_end == (LEN_W+2)'(w_head1.start))
                   && (w_sum <= (LEN_W+2)'(LEN_MAX));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.mode)
                        MODE_ALLOC: n_state = (i_in.count == '0) ? S_DONE : S_SCAN;
                        MODE_FREE:  n_state = S_DONE;
                        MODE_FRAME: n_state = (r_changed && r_used > FCNT_W'(1))
                                            ? S_SORT : S_REL_START;
                        MODE_INIT:  n_state = S_REL_RD;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_step == FCNT_W'(FREE_ENTRIES - 1)) n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = (r_exact || r_n != '0) ? S_ADD : S_DONE;
            end
            S_ADD:  n_state = S_DONE;
            S_SORT: begin
                if (r_step == FCNT_W'(FREE_ENTRIES - 1)) n_state = S_MERGE;
            end
            S_MERGE: begin
                if (r_mlen == '0) n_state = S_ALIGN;
            end
            S_ALIGN: begin
                if (r_step == '0) n_state = S_REL_START;
            end
            S_REL_START: n_state = S_REL_RD;
            S_REL_RD: begin
                if (w_rel_more) begin
                    n_state = S_REL_WR;
                end else if (!r_is_init) begin
                    n_state = S_DONE;
                end else if (r_rel_slot == SLOT_W'(FRAME_SLOTS - 1)) begin
                    n_state = S_INIT_SET;
                end
            end
            S_REL_WR:   n_state = S_REL_SUB;
            S_REL_SUB:  n_state = S_REL_RD;
            S_INIT_SET: n_state = S_DONE;
            S_DONE: begin
                if (w_done_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // chain control and handshake outputs
    always_comb begin
        w_cctl     = '0;
        w_cctl.op  = COP_HOLD;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_SCAN: begin
                w_cctl.op = COP_ROT;
            end
            S_APPLY: begin
                if (r_exact) begin
                    w_cctl.op    = COP_WRITE;
                    w_cctl.idx   = r_exact_idx;
                    w_cctl.wdata = r_last;
                end else if (r_n != '0) begin
                    w_cctl.op          = COP_WRITE;
                    w_cctl.idx         = r_best_idx;
                    w_cctl.wdata.start = r_best.start + r_cnt[START_W-1:0];
                    w_cctl.wdata.len   = r_best.len - r_cnt;
                end
            end
            S_SORT: begin
                w_cctl.op  = COP_SORT;
                w_cctl.odd = r_step[0];
                w_cctl.lim = r_used;
            end
            S_MERGE: begin
                if (r_mlen != '0) begin
                    if (w_merge) begin
                        w_cctl.op          = COP_MDEL;
                        w_cctl.lim         = r_mlen;
                        w_cctl.wdata.start = w_head0.start;
                        w_cctl.wdata.len   = w_sum[LEN_W-1:0];
                    end else begin
                        w_cctl.op = COP_ROT;
                    end
                end
            end
            S_ALIGN: begin
                if (r_step != '0) w_cctl.op = COP_ROT;
            end
            S_REL_WR: begin
                if (w_rel_push) begin
                    w_cctl.op    = COP_WRITE;
                    w_cctl.idx   = r_used[FIDX_W-1:0];
                    w_cctl.wdata = w_rdata;
                end
            end
            S_INIT_SET: begin
                if (w_init_n != '0) begin
                    w_cctl.op          = COP_WRITE;
                    w_cctl.idx         = '0;
                    w_cctl.wdata.start = '0;
                    w_cctl.wdata.len   = w_init_n;
                end
            end
            default: begin
                w_cctl.op = COP_HOLD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs      <= VS_RESET;
            r_used    <= '0;
            r_slot    <= '0;
            r_changed <= 1'b0;
            r_bytes   <= '0;
            for (int s = 0; s < FRAME_SLOTS; s++) begin
                r_dused[s] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_vs <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (w_mem_we) r_dused[r_slot] <= w_dcnt + DCNT_W'(1);
                end
                S_APPLY: begin
                    if (r_exact) begin
                        r_used    <= r_used - FCNT_W'(1);
                        r_changed <= 1'b1;
                    end else if (r_n != '0) begin
                        r_changed <= 1'b1;
                    end
                end
                S_ADD: begin
                    r_bytes <= sat_add(r_bytes, r_prod);
                end
                S_MERGE: begin
                    if (r_mlen == '0) begin
                        r_used    <= r_fin;
                        r_changed <= 1'b0;
                    end
                end
                S_REL_START: begin
                    r_slot <= (r_slot == '0) ? SLOT_W'(FRAME_SLOTS - 1)
                                             : r_slot - SLOT_W'(1);
                end
                S_REL_RD: begin
                    if (!w_rel_more) r_dused[r_rel_slot] <= '0;
                end
                S_REL_WR: begin
                    if (w_rel_push) begin
                        r_used    <= r_used + FCNT_W'(1);
                        r_changed <= 1'b1;
                    end
                end
                S_REL_SUB: begin
                    r_bytes <= sat_sub(r_bytes, r_prod);
                end
                S_INIT_SET: begin
                    r_used    <= (w_init_n != '0) ? FCNT_W'(1) : '0;
                    r_changed <= 1'b0;
                end
                default: begin
                    r_used <= r_used;
                end
            endcase
        end
    end

    // per-request working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cnt      <= i_in.count;
                r_is_init  <= (i_in.mode == MODE_INIT);
                r_step     <= '0;
                r_exact    <= 1'b0;
                r_n        <= '0;
                r_stop     <= 1'b0;
                r_ridx     <= '0;
                r_drop     <= 1'b0;
                r_rel_slot <= '0;
                r_mlen     <= r_used;
                r_fin      <= '0;
                r_gs       <= '0;
                r_gl       <= '0;
                r_st       <= (i_in.mode == MODE_FREE && w_dfull) ? ST_DEF_FULL : ST_OK;
            end
            S_SCAN: begin
                if (w_live && !r_stop) begin
                    if (w_head0.len == r_cnt) begin
                        r_exact     <= 1'b1;
                        r_exact_idx <= r_step[FIDX_W-1:0];
                        r_gs        <= w_head0.start;
                        r_stop      <= 1'b1;
                    end else if (w_head0.len > r_cnt) begin
                        if (r_n == '0 || w_head0.len < r_best.len) begin
                            r_best     <= w_head0;
                            r_best_idx <= r_step[FIDX_W-1:0];
                        end
                        r_n <= r_n + SCAN_W'(1);
                        if (r_n + SCAN_W'(1) >= SCAN_W'(SCAN_LIMIT)) r_stop <= 1'b1;
                    end
                end
                // hold the last live entry for the exact-fit backfill
                if ({1'b0, r_step[FIDX_W-1:0]} == r_used - FCNT_W'(1)) r_last <= w_head0;
                r_step <= r_step + FCNT_W'(1);
            end
            S_APPLY: begin
                r_prod <= PROD_W'(r_cnt) * PROD_W'(r_vs);
                if (r_exact) begin
                    r_gl <= r_cnt;
                end else if (r_n != '0) begin
                    r_gs <= r_best.start;
                    r_gl <= r_cnt;
                end else begin
                    r_st <= ST_NO_FIT;
                end
            end
            S_SORT: begin
                r_step <= (r_step == FCNT_W'(FREE_ENTRIES - 1)) ? '0 : r_step + FCNT_W'(1);
                r_mlen <= r_used;
            end
            S_MERGE: begin
                if (r_mlen == '0) begin
                    r_step <= FCNT_W'(FREE_ENTRIES) - r_fin;
                end else begin
                    r_mlen <= r_mlen - FCNT_W'(1);
                    if (!w_merge) r_fin <= r_fin + FCNT_W'(1);
                end
            end
            S_ALIGN: begin
                if (r_step != '0) r_step <= r_step - FCNT_W'(1);
            end
            S_REL_START: begin
                r_rel_slot <= (r_slot == '0) ? SLOT_W'(FRAME_SLOTS - 1)
                                             : r_slot - SLOT_W'(1);
            end
            S_REL_RD: begin
                if (!w_rel_more) begin
                    if (!r_is_init) begin
                        r_st <= r_drop ? ST_FREE_FULL : ST_OK;
                    end else begin
                        r_rel_slot <= r_rel_slot + SLOT_W'(1);
                        r_ridx     <= '0;
                    end
                end
            end
            S_REL_WR: begin
                r_prod <= PROD_W'(w_rdata.len) * PROD_W'(r_vs);
                if (!r_is_init && w_rdata.len != '0 && !w_rel_push) r_drop <= 1'b1;
            end
            S_REL_SUB: begin
                r_ridx <= r_ridx + DCNT_W'(1);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done_load) begin
            r_out.grant_start     <= r_gs;
            r_out.grant_length    <= r_gl;
            r_out.status          <= r_st;
            r_out.allocated_bytes <= r_bytes;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    `VRA_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= FCNT_W'(FREE_ENTRIES), "free count past list size")
    `VRA_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(r_state) == S_DONE, "result loaded outside done state")
    `VRA_ASSERT(a_merge_count, i_clk, i_rst_n, (r_state == S_MERGE) |-> ((FCNT_W+1)'(r_mlen) + (FCNT_W+1)'(r_fin) <= (FCNT_W+1)'(r_used)), "merge pass lost track of entries")
    `VRA_ASSERT(a_defer_bound, i_clk, i_rst_n, w_dcnt <= DCNT_W'(DEFERRED_DEPTH), "deferred count past depth")

endmodule

FILE: rtl/core/vra_cell.sv
// One free list cell: holds an entry, loads it or takes a neighbor's.
module vra_cell (
    input  logic               i_clk,
    input  vra_pkg::t_cell_ctl i_ctl,
    input  vra_pkg::t_entry    i_right,
    input  vra_pkg::t_entry    i_left,
    input  vra_pkg::t_entry    i_wdata,
    output vra_pkg::t_entry    o_q
);
    import vra_pkg::*;

    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_q <= i_wdata;
        end else if (i_ctl.take_r) begin
            r_q <= i_right;
        end else if (i_ctl.take_l) begin
            r_q <= i_left;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/core/vra_dmem.sv
// Deferred range memory, one write and one registered read port.
module vra_dmem (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [vra_pkg::DADDR_W-1:0] i_waddr,
    input  vra_pkg::t_entry             i_wdata,
    input  logic                        i_re,
    input  logic [vra_pkg::DADDR_W-1:0] i_raddr,
    output vra_pkg::t_entry             o_rdata
);
    import vra_pkg::*;

    t_entry r_mem [2**DADDR_W];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/vra_chain.sv
// Row of free list cells with rotate, sort, delete and write controls.
module vra_chain (
    input  logic                i_clk,
    input  vra_pkg::t_chain_ctl i_ctl,
    output vra_pkg::t_entry     o_head0,
    output vra_pkg::t_entry     o_head1
);
    import vra_pkg::*;

    t_entry    w_q   [FREE_ENTRIES];
    t_cell_ctl w_ctl [FREE_ENTRIES];
    logic      w_swap [FREE_ENTRIES];

    // odd-even transposition: boundary k pairs cell k with cell k+1
    always_comb begin
        for (int k = 0; k < FREE_ENTRIES; k++) begin
            w_swap[k] = 1'b0;
            if (k < FREE_ENTRIES - 1) begin
                w_swap[k] = (k[0] == i_ctl.odd) && (FCNT_W'(k + 1) < i_ctl.lim)
                          && (w_q[k].start > w_q[k + 1].start);
            end
        end
    end

    always_comb begin
        for (int k = 0; k < FREE_ENTRIES; k++) begin
            w_ctl[k] = '0;
            case (i_ctl.op)
                COP_ROT: begin
                    w_ctl[k].take_r = 1'b1;
                end
                COP_SORT: begin
                    w_ctl[k].take_r = w_swap[k];
                    w_ctl[k].take_l = (k > 0) ? w_swap[(k > 0) ? k - 1 : 0] : 1'b0;
                end
                COP_MDEL: begin
                    // cell 0 absorbs cell 1; close the gap inside the live part
                    w_ctl[k].load   = (k == 0);
                    w_ctl[k].take_r = (k >= 1) && (FCNT_W'(k + 1) < i_ctl.lim);
                end
                COP_WRITE: begin
                    w_ctl[k].load = (FIDX_W'(k) == i_ctl.idx);
                end
                default: begin
                    w_ctl[k] = '0;
                end
            endcase
        end
    end

    for (genvar g = 0; g < FREE_ENTRIES; g++) begin : g_cell
        vra_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl[g]),
            .i_right(w_q[(g + 1) % FREE_ENTRIES]),
            .i_left (w_q[(g + FREE_ENTRIES - 1) % FREE_ENTRIES]),
            .i_wdata(i_ctl.wdata),
            .o_q    (w_q[g])
        );
    end

    assign o_head0 = w_q[0];
    assign o_head1 = w_q[1];

endmodule

FILE: tb/sv/vertex_range_allocator_core_tb.sv
// Self-checking testbench for the vertex range allocator core.
`timescale 1ns / 100ps

module vertex_range_allocator_core_tb;
    import vra_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int RANDOM_ITEMS = 660;
    localparam int SETTLE_CYCLES = 600;

    typedef struct {
        t_mode            mode;
        logic [LEN_W-1:0]   count;
        logic [START_W-1:0] start_req;
        bit               known;
        t_out             result;
    } t_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    t_in           i_in = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    t_out          o_out;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [VS_W-1:0] i_cfg_data = '0;

    vertex_range_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Allocator shadow state
    logic [START_W-1:0] pool_start [FREE_ENTRIES];
    logic [LEN_W-1:0]   pool_len [FREE_ENTRIES];
    int                 pool_used;
    logic [START_W-1:0] hold_start [FRAME_SLOTS][DEFERRED_DEPTH];
    logic [LEN_W-1:0]   hold_len [FRAME_SLOTS][DEFERRED_DEPTH];
    int                 hold_used [FRAME_SLOTS];
    int                 cur_slot;
    bit                 pool_dirty;
    longint             byte_total;
    logic [VS_W-1:0]    bytes_per_vert;

    t_out  grant_queue [$];
    int    failures = 0;
    int    cycles = 0;
    bit    hold_off = 1'b0;
    bit    sender_done = 1'b0;
    int    rx_wait = 0;

    function automatic void add_bytes(logic [LEN_W-1:0] n);
        byte_total += longint'(n) * longint'(bytes_per_vert);
        if (byte_total > longint'(BYTES_MAX)) byte_total = longint'(BYTES_MAX);
    endfunction

    function automatic void sub_bytes(logic [LEN_W-1:0] n);
        longint b;
        b = longint'(n) * longint'(bytes_per_vert);
        byte_total = (b > byte_total) ? 0 : byte_total - b;
    endfunction

    function automatic void merge_pool();
        int i, j;
        logic [START_W-1:0] s;
        logic [LEN_W-1:0] l;
        longint fin, sum;
        if (!pool_dirty || pool_used <= 1) return;
        for (i = 1; i < pool_used; i++) begin
            s = pool_start[i];
            l = pool_len[i];
            j = i;
            while (j > 0 && pool_start[j-1] > s) begin
                pool_start[j] = pool_start[j-1];
                pool_len[j] = pool_len[j-1];
                j--;
            end
            pool_start[j] = s;
            pool_len[j] = l;
        end
        i = 0;
        while (i + 1 < pool_used) begin
            fin = longint'(pool_start[i]) + longint'(pool_len[i]);
            sum = longint'(pool_len[i]) + longint'(pool_len[i+1]);
            if (fin == longint'(pool_start[i+1]) && sum <= longint'(LEN_MAX)) begin
                pool_len[i] = LEN_W'(sum);
                for (j = i + 1; j + 1 < pool_used; j++) begin
                    pool_start[j] = pool_start[j+1];
                    pool_len[j] = pool_len[j+1];
                end
                pool_used--;
            end else begin
                i++;
            end
        end
        pool_dirty = 1'b0;
    endfunction

    function automatic bit release_slot(int slot);
        bit dropped;
        dropped = 1'b0;
        for (int i = 0; i < hold_used[slot]; i++) begin
            sub_bytes(hold_len[slot][i]);
            if (hold_len[slot][i] != 0) begin
                if (pool_used < FREE_ENTRIES) begin
                    pool_start[pool_used] = hold_start[slot][i];
                    pool_len[pool_used] = hold_len[slot][i];
                    pool_used++;
                    pool_dirty = 1'b1;
                end else begin
                    dropped = 1'b1;
                end
            end
        end
        hold_used[slot] = 0;
        return dropped;
    endfunction

    function automatic void reset_shadow();
        pool_used = 0;
        for (int k = 0; k < FRAME_SLOTS; k++) hold_used[k] = 0;
        cur_slot = 0;
        pool_dirty = 1'b0;
        byte_total = 0;
        bytes_per_vert = VS_RESET;
    endfunction

    function automatic t_out predict_grant(t_in req);
        t_out r;
        int n, best;
        bit found;
        logic [LEN_W-1:0] lim;
        r = '0;
        r.status = ST_OK;
        case (req.mode)
            MODE_ALLOC: begin
                if (req.count != 0) begin
                    found = 1'b0;
                    n = 0;
                    best = 0;
                    for (int i = 0; i < pool_used; i++) begin
                        if (pool_len[i] == req.count) begin
                            r.grant_start = pool_start[i];
                            r.grant_length = req.count;
                            pool_used--;
                            pool_start[i] = pool_start[pool_used];
                            pool_len[i] = pool_len[pool_used];
                            pool_dirty = 1'b1;
                            found = 1'b1;
                            break;
                        end
                        if (pool_len[i] > req.count) begin
                            if (n == 0 || pool_len[i] < pool_len[best]) best = i;
                            n++;
                            if (n >= SCAN_LIMIT) break;
                        end
                    end
                    if (!found && n > 0) begin
                        r.grant_start = pool_start[best];
                        r.grant_length = req.count;
                        pool_start[best] = pool_start[best] + START_W'(req.count);
                        pool_len[best] = pool_len[best] - req.count;
                        pool_dirty = 1'b1;
                        found = 1'b1;
                    end
                    if (found) add_bytes(r.grant_length);
                    else r.status = ST_NO_FIT;
                end
            end
            MODE_FREE: begin
                if (hold_used[cur_slot] < DEFERRED_DEPTH) begin
                    hold_start[cur_slot][hold_used[cur_slot]] = req.start_req;
                    hold_len[cur_slot][hold_used[cur_slot]] = req.count;
                    hold_used[cur_slot]++;
                end else begin
                    r.status = ST_DEF_FULL;
                end
            end
            MODE_FRAME: begin
                merge_pool();
                cur_slot = (cur_slot == 0) ? FRAME_SLOTS - 1 : cur_slot - 1;
                if (release_slot(cur_slot)) r.status = ST_FREE_FULL;
            end
            default: begin
                for (int k = 0; k < FRAME_SLOTS; k++) void'(release_slot(k));
                lim = (req.count > POOL_CAP) ? POOL_CAP : req.count;
                pool_used = 0;
                if (lim != 0) begin
                    pool_start[0] = '0;
                    pool_len[0] = lim;
                    pool_used = 1;
                end
                pool_dirty = 1'b0;
            end
        endcase
        r.allocated_bytes = BYTES_W'(byte_total);
        return r;
    endfunction

    // Receiver side: random stalls between results, one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_out_stall <= 1'b1;
        end else if (rx_wait != 0) begin
            rx_wait = rx_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (o_out_valid) rx_wait = $urandom_range(0, 17);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (grant_queue.size() == 0) begin
                $error("unexpected result %p", o_out);
                failures++;
            end else begin
                want = grant_queue.pop_front();
                if (o_out.grant_start !== want.grant_start) begin
                    $error("grant_start exp %0d got %0d", want.grant_start, o_out.grant_start);
                    failures++;
                end
                if (o_out.grant_length !== want.grant_length) begin
                    $error("grant_length exp %0d got %0d", want.grant_length,
                           o_out.grant_length);
                    failures++;
                end
                if (o_out.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, o_out.status);
                    failures++;
                end
                if (o_out.allocated_bytes !== want.allocated_bytes) begin
                    $error("allocated_bytes exp %0d got %0d", want.allocated_bytes,
                           o_out.allocated_bytes);
                    failures++;
                end
            end
        end
    end

    // Offer one request; hold it until accepted, then predict its grant
    task automatic send_request(t_in req, bit known, t_out result);
        t_out r;
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        r = predict_grant(req);
        if (known && r != result) begin
            $error("table row mismatch: exp %p model %p", result, r);
            failures++;
        end
        grant_queue.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (grant_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_vertex_size(logic [VS_W-1:0] v);
        drain_results();
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        bytes_per_vert = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in make_req(t_mode m, int c, int s);
        t_in q;
        q.mode = m;
        q.count = LEN_W'(c);
        q.start_req = START_W'(s);
        return q;
    endfunction

    // Draw a random request, mostly well-formed allocator traffic
    function automatic t_in random_req();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return make_req(MODE_ALLOC, ($urandom_range(0, 9) == 0) ?
                                   $urandom_range(0, 2097151) : $urandom_range(0, 4096), 0);
        if (p < 80) return make_req(MODE_FREE, ($urandom_range(0, 9) == 0) ?
                                   $urandom_range(0, 2097151) : $urandom_range(0, 4096),
                                   $urandom_range(0, 1048575));
        if (p < 97) return make_req(MODE_FRAME, $urandom, $urandom);
        return make_req(MODE_INIT, ($urandom_range(0, 1) == 0) ? 1048576 :
                        $urandom_range(0, 2097151), $urandom);
    endfunction

    t_row directed [$];

    task automatic add_row(t_mode m, int c, int s, bit known, int gs, int gl,
                           t_status st, int bytes);
        t_row row;
        row.mode = m;
        row.count = LEN_W'(c);
        row.start_req = START_W'(s);
        row.known = known;
        row.result.grant_start = START_W'(gs);
        row.result.grant_length = LEN_W'(gl);
        row.result.status = st;
        row.result.allocated_bytes = BYTES_W'(bytes);
        directed.push_back(row);
    endtask

    initial begin
        t_out none;
        t_in req;
        none = '0;
        reset_shadow();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // After reset: empty pool, no fit; zero request grants nothing
        add_row(MODE_ALLOC, 5, 0, 1, 0, 0, ST_NO_FIT, 0);
        add_row(MODE_ALLOC, 0, 0, 1, 0, 0, ST_OK, 0);
        add_row(MODE_INIT, 2097151, 1048575, 1, 0, 0, ST_OK, 0);
        add_row(MODE_ALLOC, 100, 0, 1, 0, 100, ST_OK, 3200);
        add_row(MODE_ALLOC, 1048476, 0, 1, 100, 1048476, ST_OK, 33554432);
        add_row(MODE_ALLOC, 1, 0, 1, 0, 0, ST_NO_FIT, 33554432);
        add_row(MODE_FREE, 100, 0, 1, 0, 0, ST_OK, 33554432);
        add_row(MODE_FREE, 0, 1048575, 1, 0, 0, ST_OK, 33554432);
        add_row(MODE_FRAME, 0, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_FRAME, 0, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_ALLOC, 40, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_ALLOC, 60, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_ALLOC, 2097151, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_INIT, 0, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_ALLOC, 1, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_INIT, 1000, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_ALLOC, 999, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_FREE, 2097151, 1048575, 0, 0, 0, ST_OK, 0);
        add_row(MODE_FRAME, 0, 0, 0, 0, 0, ST_OK, 0);
        add_row(MODE_FRAME, 0, 0, 0, 0, 0, ST_OK, 0);
        foreach (directed[k])
            send_request(make_req(directed[k].mode, directed[k].count,
                                  directed[k].start_req), directed[k].known,
                         directed[k].result);

        // Deferred overflow: fill one slot past its depth
        for (int k = 0; k < DEFERRED_DEPTH + 2; k++)
            send_request(make_req(MODE_FREE, $urandom_range(1, 50), k * 100), 0, none);
        send_request(make_req(MODE_FRAME, 0, 0), 0, none);
        send_request(make_req(MODE_FRAME, 0, 0), 0, none);

        // Free list overflow: fragment the pool, then release many ranges
        write_vertex_size(VS_W'(256));
        send_request(make_req(MODE_INIT, 1048576, 0), 0, none);
        for (int k = 0; k < 62; k++)
            send_request(make_req(MODE_FREE, 3, k * 16 + 500000), 0, none);
        for (int k = 0; k < 3; k++) send_request(make_req(MODE_FRAME, 0, 0), 0, none);
        for (int k = 0; k < 64; k++)
            send_request(make_req(MODE_FREE, 2, k * 16 + 700000), 0, none);
        for (int k = 0; k < 3; k++) send_request(make_req(MODE_FRAME, 0, 0), 0, none);

        write_vertex_size(VS_W'(1));
        send_request(make_req(MODE_INIT, 1048576, 0), 0, none);

        // Long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (1500) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 20; k++) send_request(random_req(), 0, none);
                i_in_valid <= 1'b0;
            end
        join
        @(negedge i_clk);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == 300) write_vertex_size(VS_W'($urandom_range(1, 256)));
            if (k == 600) write_vertex_size(VS_W'(511));
            if (k == 450) drain_results();
            req = random_req();
            send_request(req, 0, none);
        end

        drain_results();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
